[hw/rtl/breathing_led_arc_profile_defines.svh]
// ============================================================================
// Breathing LED arc profile: assertion macros
// Shared macros for the concurrent checks of the breathing LED block.
// ============================================================================
`ifndef BREATHING_LED_ARC_PROFILE_DEFINES_SVH
`define BREATHING_LED_ARC_PROFILE_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define BLAP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define BLAP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/blap_pkg.sv]
// ============================================================================
// Breathing LED arc profile package
// Codes, reset values and the command and status bundles shared by the
// controller and the datapath.
// ============================================================================
package blap_pkg;

    // Ambient light class codes; any other code keeps the current radius.
    localparam logic [1:0] CLASS_DAY   = 2'd0;
    localparam logic [1:0] CLASS_NIGHT = 2'd1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DAY_RADIUS   = 2'd0;
    localparam logic [1:0] CFG_NIGHT_RADIUS = 2'd1;
    localparam logic [1:0] CFG_MIN_LEVEL    = 2'd2;
    localparam logic [1:0] CFG_MAX_DUTY     = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [7:0] RST_DAY_RADIUS   = 8'd100;
    localparam logic [7:0] RST_NIGHT_RADIUS = 8'd130;
    localparam logic [7:0] RST_MIN_LEVEL    = 8'd3;
    localparam logic [7:0] RST_MAX_DUTY     = 8'd99;

    // Number of root digits produced by the square root unit, minus one.
    localparam logic [2:0] ROOT_LAST_STEP = 3'd7;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // take a new tick
        logic square;     // form radius^2 - d^2
        logic root_step;  // produce one root digit
        logic emit_load;  // move the level into the output register
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic root_last;  // current root step is the last one
        logic has_result; // level is inside the emit window
        logic out_full;   // output register holds a word not yet taken
    } dp_status_t;

endpackage

[hw/rtl/blap_ctrl.sv]
// ============================================================================
// Breathing LED arc profile controller
// Sequences one tick through load, squaring, the square root steps and the
// hand-off to the output register.
// ============================================================================
module blap_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  out_ready,
    input  blap_pkg::dp_status_t  status,
    output blap_pkg::ctl_cmd_t    cmd
);
    import blap_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SQUARE = 4'b0010,
        ST_ROOT   = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (status.root_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // A tick with no level finishes at once; a level waits for room.
                if (!status.has_result)
                begin
                    state_next = ST_IDLE;
                end
                else if (!status.out_full || out_ready)
                begin
                    cmd.emit_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/blap_datapath.sv]
// ============================================================================
// Breathing LED arc profile datapath
// Configuration registers, tick counter, arc radius, the squaring stage, a
// two-bits-per-step square root unit and the output register.
// ============================================================================
module blap_datapath #(
    parameter int HALF_PERIOD = 100
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data,
    input  logic [1:0]            light_class,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [7:0]            blue_duty,
    input  blap_pkg::ctl_cmd_t    cmd,
    output blap_pkg::dp_status_t  status
);
    import blap_pkg::*;

    localparam logic [7:0] HALF   = 8'(HALF_PERIOD);
    localparam logic [7:0] PERIOD = 8'(2 * HALF_PERIOD);

    // Configuration and state registers.
    logic [7:0]  day_radius_reg;
    logic [7:0]  night_radius_reg;
    logic [7:0]  min_level_reg;
    logic [7:0]  max_duty_reg;
    logic [7:0]  tick_count_reg;
    logic [7:0]  tick_count_next;
    logic [7:0]  arc_radius_reg;
    logic [7:0]  arc_radius_next;

    // Per-tick working registers.
    logic [7:0]  r_reg;
    logic [7:0]  d_reg;
    logic        wrap_reg;
    logic        mid_reg;
    logic [15:0] v_reg;
    logic [8:0]  rem_reg;
    logic [7:0]  root_reg;
    logic [2:0]  step_reg;

    // Output register.
    logic        out_valid_reg;
    logic [7:0]  out_data_reg;

    logic [7:0]  cnt;
    logic        wrap;
    logic [7:0]  arc_offset;
    logic [7:0]  r_eff;
    logic [15:0] r_sq;
    logic [15:0] d_sq;
    logic [10:0] rem_shift;
    logic [10:0] trial;
    logic        digit;
    logic [7:0]  level;

    // Radius choice and counter advance for an incoming tick.
    always_comb
    begin
        case (light_class)
            CLASS_DAY:   arc_radius_next = day_radius_reg;
            CLASS_NIGHT: arc_radius_next = night_radius_reg;
            default:     arc_radius_next = arc_radius_reg;
        endcase
        cnt             = tick_count_reg + 8'd1;
        wrap            = (cnt > PERIOD);
        tick_count_next = wrap ? 8'd0 : cnt;
        arc_offset      = (cnt < HALF) ? cnt : (PERIOD - cnt);
        r_eff           = (arc_radius_next < HALF) ? HALF : arc_radius_next;
    end

    // Squares of radius and distance.
    assign r_sq = 16'(r_reg * r_reg);
    assign d_sq = 16'(d_reg * d_reg);

    // One square root digit: bring down two bits and try the next odd term.
    assign rem_shift = {rem_reg, v_reg[15:14]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign digit     = (rem_shift >= trial);

    // Level and the emit window.
    assign level = mid_reg ? 8'd0 : (r_reg - root_reg);

    assign status.root_last  = (step_reg == 3'd0);
    assign status.has_result = !wrap_reg && (level >= min_level_reg) &&
                               (level <= max_duty_reg);
    assign status.out_full   = out_valid_reg;

    // Control registers: configuration, counter, radius, root step, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_radius_reg   <= RST_DAY_RADIUS;
            night_radius_reg <= RST_NIGHT_RADIUS;
            min_level_reg    <= RST_MIN_LEVEL;
            max_duty_reg     <= RST_MAX_DUTY;
            tick_count_reg   <= 8'd0;
            arc_radius_reg   <= RST_DAY_RADIUS;
            out_valid_reg    <= 1'b0;
            step_reg         <= ROOT_LAST_STEP;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_DAY_RADIUS:   day_radius_reg   <= cfg_data;
                    CFG_NIGHT_RADIUS: night_radius_reg <= cfg_data;
                    CFG_MIN_LEVEL:    min_level_reg    <= cfg_data;
                    CFG_MAX_DUTY:     max_duty_reg     <= cfg_data;
                    default:          ;
                endcase
            end
            if (cmd.load)
            begin
                tick_count_reg <= tick_count_next;
                arc_radius_reg <= arc_radius_next;
            end
            if (cmd.square)
            begin
                step_reg <= ROOT_LAST_STEP;
            end
            else if (cmd.root_step)
            begin
                step_reg <= step_reg - 3'd1;
            end
            if (cmd.emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            r_reg    <= r_eff;
            d_reg    <= arc_offset;
            wrap_reg <= wrap;
            mid_reg  <= (cnt == HALF);
        end
        if (cmd.square)
        begin
            v_reg    <= r_sq - d_sq;
            rem_reg  <= 9'd0;
            root_reg <= 8'd0;
        end
        else if (cmd.root_step)
        begin
            v_reg    <= {v_reg[13:0], 2'b00};
            rem_reg  <= digit ? 9'(rem_shift - trial) : rem_shift[8:0];
            root_reg <= {root_reg[6:0], digit};
        end
        if (cmd.emit_load)
        begin
            out_data_reg <= level;
        end
    end

    assign out_valid = out_valid_reg;
    assign blue_duty = out_data_reg;

endmodule

[hw/rtl/breathing_led_arc_profile.sv]
// ============================================================================
// Breathing LED arc profile
// Blue LED breathing brightness from a circular arc, one word per timer tick.
// ============================================================================
// Each accepted tick word is worked through before the next one is taken:
// a load, the squaring of radius and distance, and eight steps of the integer
// square root, which produces one root digit per cycle, then the hand-off of the
// level to the output register. A level waiting in the output register does
// not block work on the next tick; the hand-off waits only if that register
// is still full. Ticks that wrap the counter or fall outside the
// min_level..max_duty window produce no output word. Configuration registers
// take writes at any time and are meant to change only while the block is idle.
module breathing_led_arc_profile #(
    parameter int HALF_PERIOD = 100
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] light_class,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] blue_duty
);
    import blap_pkg::*;

    `include "breathing_led_arc_profile_defines.svh"

    ctl_cmd_t   cmd;
    dp_status_t status;

    // Sequencer.
    blap_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic and storage.
    blap_datapath #(
        .HALF_PERIOD (HALF_PERIOD)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .light_class (light_class),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .blue_duty   (blue_duty),
        .cmd         (cmd),
        .status      (status)
    );

    // Checks on the controller and datapath cooperation.
    `BLAP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted a word while busy")
    `BLAP_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0({cmd.load, cmd.square, cmd.root_step, cmd.emit_load}), "more than one command")
    `BLAP_ASSERT_NOW(a_no_overwrite, cmd.emit_load, !status.out_full || out_ready, "output word overwritten")
    `BLAP_ASSERT_NEXT(a_emit_shows, cmd.emit_load, out_valid, "loaded level not shown")

endmodule
